>>> hdl/salt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salt_pkg: shared definitions of the lockable LRU tag directory
// Access kinds, result codes, fixed field widths and the scan result record.
// ----------------------------------------------------------------------------
package salt_pkg;

    localparam int KIND_W    = 2;
    localparam int SET_IN_W  = 8;
    localparam int TAG_IN_W  = 20;
    localparam int OUTCOME_W = 3;
    localparam int WAY_OUT_W = 2;

    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INVAL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOCK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

    localparam logic [OUTCOME_W-1:0] OUT_HIT        = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL       = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT      = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_ALL_LOCKED = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_LOCK_ERR   = 3'd4;
    localparam logic [OUTCOME_W-1:0] OUT_INVAL_DONE = 3'd5;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic                 any_match;
    } scan_t;

endpackage
`default_nettype wire

>>> hdl/salt_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salt_scan: way scan of one set
// Finds the hit, the first free way or the LRU victim of a set read from the
// directory, and classifies the access.
// ----------------------------------------------------------------------------
module salt_scan #(
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20,
    parameter int RANK_W   = 2,
    parameter int WAY_W    = 2
) (
    input  wire logic [WAYS-1:0]               valid,
    input  wire logic [WAYS-1:0]               locked,
    input  wire logic [WAYS-1:0][TAG_BITS-1:0] tags,
    input  wire logic [WAYS-1:0][RANK_W-1:0]   ranks,
    input  wire logic [TAG_BITS-1:0]           req_tag,
    input  wire logic                          is_inval,
    output salt_pkg::scan_t                    res,
    output logic [WAY_W-1:0]                   sel_way,
    output logic [WAYS-1:0]                    match
);

    logic [WAYS-1:0]   event_vec;
    logic              ev_found;
    logic [WAY_W-1:0]  ev_way;
    logic              m_found;
    logic [WAY_W-1:0]  m_way;
    logic              have_victim;
    logic [WAY_W-1:0]  victim;
    logic [RANK_W-1:0] best;

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i]     = valid[i] && (tags[i] == req_tag);
            event_vec[i] = match[i] || !valid[i];
        end
    end

    // first way that ends the scan: a hit or a free line
    always_comb
    begin
        ev_found = 1'b0;
        ev_way   = '0;
        m_found  = 1'b0;
        m_way    = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (event_vec[i])
            begin
                ev_found = 1'b1;
                ev_way   = WAY_W'(i);
            end
            if (match[i])
            begin
                m_found = 1'b1;
                m_way   = WAY_W'(i);
            end
        end
    end

    // lowest rank among unlocked lines, ties to the lowest way
    always_comb
    begin
        have_victim = 1'b0;
        victim      = '0;
        best        = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (valid[i] && !locked[i] && (!have_victim || ranks[i] < best))
            begin
                have_victim = 1'b1;
                best        = ranks[i];
                victim      = WAY_W'(i);
            end
        end
    end

    always_comb
    begin
        res.any_match = 1'b0;
        sel_way       = '0;
        priority if (is_inval)
        begin
            res.outcome   = salt_pkg::OUT_INVAL_DONE;
            res.any_match = m_found;
            sel_way       = m_way;
        end
        else if (ev_found)
        begin
            sel_way = ev_way;
            priority if (valid[ev_way])
            begin
                res.outcome   = salt_pkg::OUT_HIT;
                res.any_match = 1'b1;
            end
            else if (locked[ev_way])
            begin
                res.outcome = salt_pkg::OUT_LOCK_ERR;
            end
            else
            begin
                res.outcome = salt_pkg::OUT_FILL;
            end
        end
        else if (have_victim)
        begin
            res.outcome = salt_pkg::OUT_EVICT;
            sel_way     = victim;
        end
        else
        begin
            res.outcome = salt_pkg::OUT_ALL_LOCKED;
        end
    end

endmodule
`default_nettype wire

>>> hdl/set_assoc_lru_lockable_tags_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_lockable_tags_top: tag directory with LRU and line locking
// Set-associative tag store; each non-reserved access gives one result beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries kind, set_index and tag. Kind
//   lookup hits or allocates a line, kind invalidate clears every matching
//   way, kind fetch-and-lock allocates like lookup and locks the line. The
//   reserved kind is taken and dropped without a result.
//   Output channel (out_valid/out_stall) returns outcome, way and any_match.
//   Each access runs read, scan and write-back on the set memory, and its
//   result beat is registered as write-back completes. The one-port
//   read-modify-write of a set row keeps accesses apart: no two accesses
//   overlap, so no forwarding is needed.
//   The output register holds a result while out_stall is high; a later
//   access waits in write-back until the slot frees, with in_stall high.
//   After reset the block zeroes the set memory, one row a cycle, holding
//   in_stall high; then all lines are invalid and unlocked.
// ----------------------------------------------------------------------------
module set_assoc_lru_lockable_tags_top #(
    parameter int WAYS     = 4,
    parameter int SETS     = 256,
    parameter int TAG_BITS = 20
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [salt_pkg::KIND_W-1:0]      kind,
    input  wire logic [salt_pkg::SET_IN_W-1:0]    set_index,
    input  wire logic [salt_pkg::TAG_IN_W-1:0]    tag,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [salt_pkg::OUTCOME_W-1:0]        outcome,
    output logic [salt_pkg::WAY_OUT_W-1:0]        way,
    output logic                                  any_match
);

    localparam int RANK_W = $clog2(WAYS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LINE_W = 2 + TAG_BITS + RANK_W;
    localparam int V_BIT  = LINE_W - 1;
    localparam int L_BIT  = LINE_W - 2;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(WAYS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    typedef logic [WAYS-1:0][LINE_W-1:0] row_t;

    row_t mem [SETS];

    logic [2:0]                     state_reg, state_next;
    logic [SET_W-1:0]               clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0]               set_reg;
    logic [TAG_BITS-1:0]            tag_reg;
    logic                           lock_reg;
    logic                           inval_reg;
    row_t                           rd_row_reg;
    salt_pkg::scan_t                scan_reg;
    logic [WAY_W-1:0]               sel_reg;
    logic [WAYS-1:0]                match_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [salt_pkg::OUTCOME_W-1:0] outcome_reg;
    logic [salt_pkg::WAY_OUT_W-1:0] way_reg;
    logic                           any_match_reg;

    logic [salt_pkg::SET_IN_W-1:0]  set_rem;
    logic                           in_take;
    logic                           out_free;
    logic                           mem_we;
    logic [SET_W-1:0]               mem_waddr;
    row_t                           mem_wdata;
    row_t                           new_row;
    logic                           touch;
    logic [RANK_W-1:0]              old_rank;

    logic [WAYS-1:0]                rd_valid;
    logic [WAYS-1:0]                rd_locked;
    logic [WAYS-1:0][TAG_BITS-1:0]  rd_tag;
    logic [WAYS-1:0][RANK_W-1:0]    rd_rank;
    salt_pkg::scan_t                scan_res;
    logic [WAY_W-1:0]               scan_way;
    logic [WAYS-1:0]                scan_match;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign outcome   = outcome_reg;
    assign way       = way_reg;
    assign any_match = any_match_reg;

    // reduce the set number modulo SETS by shifted compare-subtract
    always_comb
    begin
        logic [31:0] trial;
        set_rem = set_index;
        for (int k = salt_pkg::SET_IN_W - 1; k >= 0; k--)
        begin
            trial = 32'(SETS) << k;
            if (trial <= 32'(set_rem))
            begin
                set_rem = set_rem - salt_pkg::SET_IN_W'(trial);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            rd_valid[i]  = rd_row_reg[i][V_BIT];
            rd_locked[i] = rd_row_reg[i][L_BIT];
            rd_tag[i]    = rd_row_reg[i][RANK_W +: TAG_BITS];
            rd_rank[i]   = rd_row_reg[i][RANK_W-1:0];
        end
    end

    salt_scan #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS),
        .RANK_W   (RANK_W),
        .WAY_W    (WAY_W)
    ) u_scan (
        .valid    (rd_valid),
        .locked   (rd_locked),
        .tags     (rd_tag),
        .ranks    (rd_rank),
        .req_tag  (tag_reg),
        .is_inval (inval_reg),
        .res      (scan_res),
        .sel_way  (scan_way),
        .match    (scan_match)
    );

    // build the write-back row: invalidate matches or touch the chosen way
    always_comb
    begin
        new_row  = rd_row_reg;
        old_rank = rd_rank[sel_reg];
        touch    = (scan_reg.outcome == salt_pkg::OUT_HIT)
                || (scan_reg.outcome == salt_pkg::OUT_FILL)
                || (scan_reg.outcome == salt_pkg::OUT_EVICT);
        for (int i = 0; i < WAYS; i++)
        begin
            if ((scan_reg.outcome == salt_pkg::OUT_INVAL_DONE) && match_reg[i])
            begin
                new_row[i][V_BIT]        = 1'b0;
                new_row[i][L_BIT]        = 1'b0;
                new_row[i][RANK_W-1:0]   = '0;
            end
            else if (touch)
            begin
                if (WAY_W'(i) == sel_reg)
                begin
                    new_row[i][V_BIT]              = 1'b1;
                    new_row[i][L_BIT]              = rd_locked[i] || lock_reg;
                    new_row[i][RANK_W +: TAG_BITS] = tag_reg;
                    new_row[i][RANK_W-1:0]         = RANK_TOP;
                end
                else if (rd_rank[i] > old_rank)
                begin
                    new_row[i][RANK_W-1:0] = rd_rank[i] - RANK_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = set_reg;
        mem_wdata = new_row;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if ((state_reg == ST_WRITE) && out_free)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_row_reg <= mem[set_reg];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // the reserved kind is taken and dropped
                if (in_take && (kind != salt_pkg::KIND_RSVD))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the result slot is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            set_reg   <= SET_W'(set_rem);
            tag_reg   <= TAG_BITS'(tag);
            lock_reg  <= (kind == salt_pkg::KIND_LOCK);
            inval_reg <= (kind == salt_pkg::KIND_INVAL);
        end
        if (state_reg == ST_EVAL)
        begin
            scan_reg  <= scan_res;
            sel_reg   <= scan_way;
            match_reg <= scan_match;
        end
        if ((state_reg == ST_WRITE) && out_free)
        begin
            outcome_reg   <= scan_reg.outcome;
            way_reg       <= salt_pkg::WAY_OUT_W'(sel_reg);
            any_match_reg <= scan_reg.any_match;
        end
    end

`ifndef SYNTH
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("input beat taken during memory clear");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_WRITE))
        else $error("result beat raised outside write-back");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CLEAR) || (state_reg == ST_WRITE)))
        else $error("set memory written outside clear or write-back");

    a_hold_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && out_valid_reg && out_stall) |=>
            (state_reg == ST_WRITE))
        else $error("write-back left while result slot was full");

    a_err_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            !((outcome_reg == salt_pkg::OUT_LOCK_ERR) && any_match_reg))
        else $error("lock error reported together with a match");
`endif

endmodule
`default_nettype wire

>>> tb/tb_set_assoc_lru_lockable_tags_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_lockable_tags_top: scoreboard for the lockable LRU tag directory
// Drives a table of directed accesses and then random accesses biased toward a
// few hot sets and a small tag pool. A directory model here predicts each beat
// unless a directed row gives its own; beats are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_lockable_tags_top;

    localparam int WAYS         = 4;
    localparam int SETS         = 256;
    localparam int TAG_BITS     = 20;
    localparam int RANK_W       = $clog2(WAYS);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 48;
    localparam int NUM_DIRECTED = 23;

    typedef struct packed {
        logic [salt_pkg::OUTCOME_W-1:0] outcome;
        logic [salt_pkg::WAY_OUT_W-1:0] way;
        logic                           any_match;
    } dir_result_t;

    typedef struct packed {
        logic [salt_pkg::KIND_W-1:0]    kind;
        logic [salt_pkg::SET_IN_W-1:0]  set_index;
        logic [salt_pkg::TAG_IN_W-1:0]  tag;
        logic                           has_want;
        logic [salt_pkg::OUTCOME_W-1:0] want_outcome;
        logic [salt_pkg::WAY_OUT_W-1:0] want_way;
        logic                           want_match;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic [salt_pkg::KIND_W-1:0]    kind      = '0;
    logic [salt_pkg::SET_IN_W-1:0]  set_index = '0;
    logic [salt_pkg::TAG_IN_W-1:0]  tag       = '0;
    logic                           out_stall = 1'b0;
    logic                           in_stall;
    logic                           out_valid;
    logic [salt_pkg::OUTCOME_W-1:0] outcome;
    logic [salt_pkg::WAY_OUT_W-1:0] way;
    logic                           any_match;

    // directory model, indexed [set][way]
    logic                valid_mem [SETS][WAYS];
    logic                lock_mem  [SETS][WAYS];
    logic [TAG_BITS-1:0] tag_mem   [SETS][WAYS];
    logic [RANK_W-1:0]   rank_mem  [SETS][WAYS];

    dir_result_t pending_results[$];
    stim_row_t   typed_rows[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;
    bit          hold_request   = 1'b0;
    logic [salt_pkg::SET_IN_W-1:0] hot_sets [4];
    logic [salt_pkg::TAG_IN_W-1:0] tag_pool [8];

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{salt_pkg::KIND_LOOKUP, 8'h00, 20'h00000, 1'b1, salt_pkg::OUT_FILL, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOOKUP, 8'h00, 20'h00000, 1'b1, salt_pkg::OUT_HIT, 2'd0, 1'b1},
        '{salt_pkg::KIND_LOOKUP, 8'hFF, 20'hFFFFF, 1'b1, salt_pkg::OUT_FILL, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOCK, 8'hFF, 20'hFFFFF, 1'b1, salt_pkg::OUT_HIT, 2'd0, 1'b1},
        '{salt_pkg::KIND_LOOKUP, 8'hFF, 20'h12345, 1'b1, salt_pkg::OUT_FILL, 2'd1, 1'b0},
        '{salt_pkg::KIND_LOCK, 8'hFF, 20'h54321, 1'b1, salt_pkg::OUT_FILL, 2'd2, 1'b0},
        '{salt_pkg::KIND_LOCK, 8'hFF, 20'hAAAAA, 1'b1, salt_pkg::OUT_FILL, 2'd3, 1'b0},
        // only way 1 is unlocked, so it must be the victim
        '{salt_pkg::KIND_LOOKUP, 8'hFF, 20'h55555, 1'b1, salt_pkg::OUT_EVICT, 2'd1, 1'b0},
        '{salt_pkg::KIND_LOCK, 8'hFF, 20'h55555, 1'b1, salt_pkg::OUT_HIT, 2'd1, 1'b1},
        '{salt_pkg::KIND_LOOKUP, 8'hFF, 20'h0F0F0, 1'b1, salt_pkg::OUT_ALL_LOCKED, 2'd0, 1'b0},
        '{salt_pkg::KIND_RSVD, 8'hFF, 20'h00000, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_INVAL, 8'hFF, 20'hFFFFF, 1'b1, salt_pkg::OUT_INVAL_DONE, 2'd0, 1'b1},
        '{salt_pkg::KIND_INVAL, 8'hFF, 20'hFFFFF, 1'b1, salt_pkg::OUT_INVAL_DONE, 2'd0, 1'b0},
        // invalidate also dropped the lock, so way 0 is free again
        '{salt_pkg::KIND_LOOKUP, 8'hFF, 20'h0F0F0, 1'b1, salt_pkg::OUT_FILL, 2'd0, 1'b0},
        '{salt_pkg::KIND_INVAL, 8'h00, 20'h33333, 1'b1, salt_pkg::OUT_INVAL_DONE, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOOKUP, 8'h00, 20'h00001, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOOKUP, 8'h00, 20'h00002, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOOKUP, 8'h00, 20'h00003, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOOKUP, 8'h00, 20'h00004, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOCK, 8'h00, 20'h00001, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_RSVD, 8'hAA, 20'hFFFFF, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_LOOKUP, 8'h00, 20'h00005, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0},
        '{salt_pkg::KIND_INVAL, 8'hFF, 20'h55555, 1'b0, salt_pkg::OUT_HIT, 2'd0, 1'b0}
    };

    set_assoc_lru_lockable_tags_top #(
        .WAYS     (WAYS),
        .SETS     (SETS),
        .TAG_BITS (TAG_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .set_index (set_index),
        .tag       (tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .outcome   (outcome),
        .way       (way),
        .any_match (any_match)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                valid_mem[s][w] = 1'b0;
                lock_mem[s][w]  = 1'b0;
                tag_mem[s][w]   = '0;
                rank_mem[s][w]  = '0;
            end
        end
    end

    // move a way to the newest rank, aging every way ranked above it
    function automatic void promote_way(int s, int w);
        logic [RANK_W-1:0] old_rank;
        old_rank = rank_mem[s][w];
        if (old_rank == RANK_W'(WAYS - 1))
            return;
        for (int i = 0; i < WAYS; i++)
        begin
            if (rank_mem[s][i] > old_rank)
                rank_mem[s][i] = rank_mem[s][i] - 1'b1;
        end
        rank_mem[s][w] = RANK_W'(WAYS - 1);
    endfunction

    function automatic dir_result_t lookup_or_allocate(int s, logic [TAG_BITS-1:0] t,
                                                       bit lock_line);
        dir_result_t       r;
        int                victim;
        bit                have_victim;
        logic [RANK_W-1:0] best;
        victim      = 0;
        have_victim = 1'b0;
        best        = '0;
        r           = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (valid_mem[s][i])
            begin
                if (tag_mem[s][i] == t)
                begin
                    promote_way(s, i);
                    if (lock_line)
                        lock_mem[s][i] = 1'b1;
                    r.outcome   = salt_pkg::OUT_HIT;
                    r.way       = salt_pkg::WAY_OUT_W'(i);
                    r.any_match = 1'b1;
                    return r;
                end
                if (!lock_mem[s][i] && (!have_victim || rank_mem[s][i] < best))
                begin
                    have_victim = 1'b1;
                    best        = rank_mem[s][i];
                    victim      = i;
                end
            end
            else
            begin
                r.way = salt_pkg::WAY_OUT_W'(i);
                // an invalid line that is still locked aborts the access untouched
                if (lock_mem[s][i])
                begin
                    r.outcome = salt_pkg::OUT_LOCK_ERR;
                    return r;
                end
                tag_mem[s][i]   = t;
                valid_mem[s][i] = 1'b1;
                if (lock_line)
                    lock_mem[s][i] = 1'b1;
                promote_way(s, i);
                r.outcome = salt_pkg::OUT_FILL;
                return r;
            end
        end
        if (!have_victim)
        begin
            r.outcome = salt_pkg::OUT_ALL_LOCKED;
            return r;
        end
        tag_mem[s][victim]   = t;
        valid_mem[s][victim] = 1'b1;
        if (lock_line)
            lock_mem[s][victim] = 1'b1;
        promote_way(s, victim);
        r.outcome = salt_pkg::OUT_EVICT;
        r.way     = salt_pkg::WAY_OUT_W'(victim);
        return r;
    endfunction

    function automatic dir_result_t invalidate_matches(int s, logic [TAG_BITS-1:0] t);
        dir_result_t r;
        r         = '0;
        r.outcome = salt_pkg::OUT_INVAL_DONE;
        for (int i = 0; i < WAYS; i++)
        begin
            if (valid_mem[s][i] && tag_mem[s][i] == t)
            begin
                if (!r.any_match)
                    r.way = salt_pkg::WAY_OUT_W'(i);
                r.any_match     = 1'b1;
                valid_mem[s][i] = 1'b0;
                lock_mem[s][i]  = 1'b0;
                rank_mem[s][i]  = '0;
            end
        end
        return r;
    endfunction

    // returns 0 when the access produces no result beat
    function automatic bit tag_dir_predict(logic [salt_pkg::KIND_W-1:0] k,
                                           logic [salt_pkg::SET_IN_W-1:0] si,
                                           logic [salt_pkg::TAG_IN_W-1:0] tg,
                                           output dir_result_t r);
        int                  s;
        logic [TAG_BITS-1:0] t;
        s = int'(si) % SETS;
        t = tg[TAG_BITS-1:0];
        r = '0;
        case (k)
            salt_pkg::KIND_LOOKUP: r = lookup_or_allocate(s, t, 1'b0);
            salt_pkg::KIND_INVAL:  r = invalidate_matches(s, t);
            salt_pkg::KIND_LOCK:   r = lookup_or_allocate(s, t, 1'b1);
            default:               return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        dir_result_t want;
        dir_result_t seen;
        stim_row_t   row;
        bit          gives;
        if (rst_n && in_valid && !in_stall)
        begin
            gives = tag_dir_predict(kind, set_index, tag, want);
            if (typed_rows.size() != 0)
            begin
                row = typed_rows.pop_front();
                if (row.has_want)
                    want = '{row.want_outcome, row.want_way, row.want_match};
            end
            if (gives)
                pending_results.push_back(want);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{outcome, way, any_match};
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending, outcome", seen.outcome, 0);
            else
            begin
                want = pending_results.pop_front();
                if (seen.outcome !== want.outcome)
                    report_mismatch("outcome", seen.outcome, want.outcome);
                if (seen.way !== want.way)
                    report_mismatch("way", seen.way, want.way);
                if (seen.any_match !== want.any_match)
                    report_mismatch("any_match", seen.any_match, want.any_match);
            end
        end
    end

    // receiver: random stalls, or one long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_access(input logic [salt_pkg::KIND_W-1:0] k,
                               input logic [salt_pkg::SET_IN_W-1:0] si,
                               input logic [salt_pkg::TAG_IN_W-1:0] tg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        set_index <= si;
        tag       <= tg;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_random_access(output logic [salt_pkg::KIND_W-1:0] k);
        int                            pick;
        logic [salt_pkg::SET_IN_W-1:0] si;
        logic [salt_pkg::TAG_IN_W-1:0] tg;
        pick = $urandom_range(99);
        if (pick < 55)
            k = salt_pkg::KIND_LOOKUP;
        else if (pick < 72)
            k = salt_pkg::KIND_LOCK;
        else if (pick < 95)
            k = salt_pkg::KIND_INVAL;
        else
            k = salt_pkg::KIND_RSVD;
        si = ($urandom_range(99) < 80) ? hot_sets[$urandom_range(3)]
                                       : salt_pkg::SET_IN_W'($urandom_range(255));
        tg = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(7)]
                                       : salt_pkg::TAG_IN_W'($urandom);
        send_access(k, si, tg);
    endtask

    task automatic run_random(input int count);
        logic [salt_pkg::KIND_W-1:0] k;
        int                          n;
        n = 0;
        while (n < count)
        begin
            send_random_access(k);
            if (k != salt_pkg::KIND_RSVD)
                n++;
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            hot_sets[i] = salt_pkg::SET_IN_W'($urandom);
        for (int i = 0; i < 8; i++)
            tag_pool[i] = salt_pkg::TAG_IN_W'($urandom);
        send_idle_pct  = 18;
        recv_stall_pct = 65;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            typed_rows.push_back(directed_rows[i]);
            send_access(directed_rows[i].kind, directed_rows[i].set_index,
                        directed_rows[i].tag);
        end
        run_random(700);

        // stall the output for a long stretch while accesses keep being offered
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        run_random(24);
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();

        send_idle_pct  = 65;
        recv_stall_pct = 18;
        run_random(700);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(600);
        in_valid <= 1'b0;
        @(posedge clk);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
